[design/tmrm_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// tmrm_pkg
// Types, codes and sizes shared by the typed memory region map.
// ============================================================================
package tmrm_pkg;

    localparam int MAX_REGIONS_DEF = 64;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_FIND = 1'b1;

    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_RETYPED  = 3'd1,
        ST_OVERLAP  = 3'd2,
        ST_ZERO     = 3'd3,
        ST_FULL     = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_SHIFT,
        S_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  rtype;
        logic [63:0] length;
        logic [63:0] base;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic        func;
        logic [63:0] region_base;
        logic [63:0] region_length;
        logic [7:0]  region_type;
        logic        search_from_head;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  position;
        logic [63:0] found_base;
        logic [63:0] found_length;
        logic [7:0]  found_type;
        logic [63:0] total_length;
        logic [63:0] span_length;
        logic [6:0]  region_count;
    } rsp_t;

endpackage

[design/tmrm_req_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// tmrm_req_if
// Valid/ready channel that carries one request item.
// ============================================================================
interface tmrm_req_if;
    logic              valid;
    logic              ready;
    tmrm_pkg::req_t    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/tmrm_rsp_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// tmrm_rsp_if
// Valid/ready channel that carries one result item.
// ============================================================================
interface tmrm_rsp_if;
    logic              valid;
    logic              ready;
    tmrm_pkg::rsp_t    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/tmrm_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// tmrm_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module tmrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/typed_memory_region_map.sv]
`timescale 1ns / 1ps
// ============================================================================
// typed_memory_region_map
// Ordered table of typed memory regions with add, retype and find requests.
// ============================================================================
// The block takes one request on the item channel and returns one result on
// the result channel. An add request walks the table from the head, entry by
// entry, and then moves the entries above the change up by one or two
// places, one entry per cycle, before writing up to three entries. A find
// request walks from the head or the tail, entry by entry. The table
// memory allows one read and one write per cycle. Running totals of length,
// head base and tail end are kept in registers, so no summing pass is needed.
// Reset empties the table at once; the memory contents need no clearing.
// The result sits in an output register: a new request is taken while the
// previous result still waits, and only the final step of the next request
// holds until the receiver takes the waiting result.
// ============================================================================
module typed_memory_region_map #(
    parameter int MAX_REGIONS = tmrm_pkg::MAX_REGIONS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    tmrm_req_if.sink     item,
    tmrm_rsp_if.source   result
);
    import tmrm_pkg::*;

    localparam int AW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [CW:0] MAXV = (CW + 1)'(MAX_REGIONS);

    state_t          state_reg, state_next;
    logic            func_reg, func_next;
    logic            fromhead_reg, fromhead_next;
    logic [63:0]     b_reg, b_next;
    logic [63:0]     l_reg, l_next;
    logic [7:0]      t_reg, t_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [63:0]     total_reg, total_next;
    logic [63:0]     headb_reg, headb_next;
    logic [63:0]     tail_reg, tail_next;
    logic [AW-1:0]   shptr_reg, shptr_next;
    logic [CW-1:0]   shcnt_reg, shcnt_next;
    logic [1:0]      shn_reg, shn_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   paddr_reg, paddr_next;
    logic [AW-1:0]   wa_reg [3];
    logic [AW-1:0]   wa_next [3];
    entry_t          wd_reg [3];
    entry_t          wd_next [3];
    logic [1:0]      wn_reg, wn_next;
    logic [1:0]      wi_reg, wi_next;
    status_t         st_reg, st_next;
    logic [AW-1:0]   pos_reg, pos_next;
    entry_t          rent_reg, rent_next;
    logic            ovalid_reg, ovalid_next;
    rsp_t            rsp_reg, rsp_next;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    entry_t          wdata, rd;
    logic [ENTRY_W-1:0] rdata_raw;

    tmrm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REGIONS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );
    assign rd = entry_t'(rdata_raw);

    logic [CW-1:0]  kidx;
    logic [AW-1:0]  i0;
    logic [AW:0]    i1w, i2w, pw;
    logic [AW-1:0]  i1, i2;
    logic [64:0]    e_cur, e_new;
    logic           c_gt, c_eq, room1, room2, last;
    logic [AW+5:0]  pos_ext;
    logic [CW+6:0]  cnt_ext;
    logic [CW-1:0]  rest;

    always_comb
    begin
        kidx    = fromhead_reg ? k_reg : (cnt_reg - 1'b1 - k_reg);
        i0      = kidx[AW-1:0];
        i1w     = {1'b0, i0} + (AW + 1)'(1);
        i2w     = {1'b0, i0} + (AW + 1)'(2);
        i1      = i1w[AW-1:0];
        i2      = i2w[AW-1:0];
        pw      = {1'b0, paddr_reg} + {{(AW - 1){1'b0}}, shn_reg};
        e_cur   = {1'b0, rd.base} + {1'b0, rd.length};
        e_new   = {1'b0, b_reg} + {1'b0, l_reg};
        c_gt    = e_cur > e_new;
        c_eq    = e_cur == e_new;
        room1   = ({1'b0, cnt_reg} + (CW + 1)'(1)) <= MAXV;
        room2   = ({1'b0, cnt_reg} + (CW + 1)'(2)) <= MAXV;
        last    = (k_reg + 1'b1) == cnt_reg;
        rest    = cnt_reg - k_reg - 1'b1;
        pos_ext = {6'b0, pos_reg};
        cnt_ext = {7'b0, cnt_reg};
    end

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        fromhead_next = fromhead_reg;
        b_next        = b_reg;
        l_next        = l_reg;
        t_next        = t_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        total_next    = total_reg;
        headb_next    = headb_reg;
        tail_next     = tail_reg;
        shptr_next    = shptr_reg;
        shcnt_next    = shcnt_reg;
        shn_next      = shn_reg;
        pend_next     = pend_reg;
        paddr_next    = paddr_reg;
        wa_next       = wa_reg;
        wd_next       = wd_reg;
        wn_next       = wn_reg;
        wi_next       = wi_reg;
        st_next       = st_reg;
        pos_next      = pos_reg;
        rent_next     = rent_reg;
        ovalid_next   = ovalid_reg & ~result.ready;
        rsp_next      = rsp_reg;
        item.ready    = 1'b0;
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;
        raddr         = i0;

        unique case (state_reg)
            S_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    func_next     = item.data.func;
                    fromhead_next = (item.data.func == FUNC_ADD) | item.data.search_from_head;
                    b_next        = item.data.region_base;
                    l_next        = item.data.region_length;
                    t_next        = item.data.region_type;
                    k_next        = '0;
                    state_next    = S_RD;
                end
            end
            S_RD:
            begin
                pos_next   = '0;
                rent_next  = '0;
                wi_next    = '0;
                pend_next  = 1'b0;
                shptr_next = AW'(cnt_reg - 1'b1);
                if (func_reg == FUNC_ADD && l_reg == 64'd0)
                begin
                    st_next    = ST_ZERO;
                    state_next = S_DONE;
                end
                else if (cnt_reg == '0)
                begin
                    if (func_reg == FUNC_ADD)
                    begin
                        wa_next[0] = '0;
                        wd_next[0] = '{rtype: t_reg, length: l_reg, base: b_reg};
                        wn_next    = 2'd1;
                        rent_next  = wd_next[0];
                        st_next    = ST_NEW;
                        cnt_next   = CW'(1);
                        total_next = l_reg;
                        headb_next = b_reg;
                        tail_next  = b_reg + l_reg;
                        state_next = S_WR;
                    end
                    else
                    begin
                        st_next    = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_EV;
                end
            end
            S_EV:
            begin
                state_next = S_DONE;
                shcnt_next = '0;
                if (func_reg == FUNC_FIND)
                begin
                    if (rd.length >= l_reg && rd.rtype == t_reg)
                    begin
                        st_next   = ST_NEW;
                        pos_next  = i0;
                        rent_next = rd;
                    end
                    else if (last)
                    begin
                        st_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (rd.base >= b_reg && !(rd.base == b_reg && rd.length <= l_reg))
                begin
                    if (rd.base > b_reg && !c_gt)
                    begin
                        st_next = ST_OVERLAP;
                    end
                    else if (!room1)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        wa_next[0] = i0;
                        wd_next[0] = '{rtype: t_reg, length: l_reg, base: b_reg};
                        wa_next[1] = i1;
                        wd_next[1] = '{rtype: rd.rtype, length: rd.length - l_reg,
                                       base: rd.base + l_reg};
                        wn_next    = 2'd2;
                        shn_next   = 2'd1;
                        shcnt_next = rest;
                        st_next    = ST_NEW;
                        pos_next   = i0;
                        rent_next  = wd_next[0];
                        cnt_next   = cnt_reg + 1'b1;
                        if (k_reg == '0)
                        begin
                            headb_next = b_reg;
                        end
                        state_next = S_SHIFT;
                    end
                end
                else if (rd.base == b_reg)
                begin
                    if (rd.length == l_reg)
                    begin
                        wa_next[0] = i0;
                        wd_next[0] = '{rtype: t_reg, length: rd.length, base: rd.base};
                        wn_next    = 2'd1;
                        st_next    = ST_RETYPED;
                        pos_next   = i0;
                        rent_next  = wd_next[0];
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        st_next = ST_OVERLAP;
                    end
                end
                else if (c_gt)
                begin
                    if (!room2)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        wa_next[0] = i0;
                        wd_next[0] = '{rtype: rd.rtype, length: b_reg - rd.base,
                                       base: rd.base};
                        wa_next[1] = i1;
                        wd_next[1] = '{rtype: t_reg, length: l_reg, base: b_reg};
                        wa_next[2] = i2;
                        wd_next[2] = '{rtype: rd.rtype,
                                       length: rd.length - l_reg - (b_reg - rd.base),
                                       base: b_reg + l_reg};
                        wn_next    = 2'd3;
                        shn_next   = 2'd2;
                        shcnt_next = rest;
                        st_next    = ST_NEW;
                        pos_next   = i1;
                        rent_next  = wd_next[1];
                        cnt_next   = cnt_reg + CW'(2);
                        state_next = S_SHIFT;
                    end
                end
                else if (c_eq || last)
                begin
                    if (!room1)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        wa_next[0] = i1;
                        wd_next[0] = '{rtype: t_reg, length: l_reg, base: b_reg};
                        wa_next[1] = i0;
                        wd_next[1] = '{rtype: rd.rtype, length: rd.length - l_reg,
                                       base: rd.base};
                        wn_next    = c_eq ? 2'd2 : 2'd1;
                        shn_next   = 2'd1;
                        shcnt_next = rest;
                        st_next    = ST_NEW;
                        pos_next   = i1;
                        rent_next  = wd_next[0];
                        cnt_next   = cnt_reg + 1'b1;
                        if (!c_eq)
                        begin
                            total_next = total_reg + l_reg;
                            tail_next  = b_reg + l_reg;
                        end
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_SHIFT:
            begin
                raddr = shptr_reg;
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = pw[AW-1:0];
                    wdata = rd;
                end
                if (shcnt_reg != '0)
                begin
                    pend_next  = 1'b1;
                    paddr_next = shptr_reg;
                    shptr_next = shptr_reg - 1'b1;
                    shcnt_next = shcnt_reg - 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                we      = 1'b1;
                waddr   = wa_reg[wi_reg];
                wdata   = wd_reg[wi_reg];
                wi_next = wi_reg + 1'b1;
                if (wi_next == wn_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next           = 1'b1;
                    rsp_next.status       = st_reg;
                    rsp_next.position     = pos_ext[5:0];
                    rsp_next.found_base   = rent_reg.base;
                    rsp_next.found_length = rent_reg.length;
                    rsp_next.found_type   = rent_reg.rtype;
                    rsp_next.total_length = total_reg;
                    rsp_next.span_length  = (cnt_reg == '0) ? 64'd0 : tail_reg - headb_reg;
                    rsp_next.region_count = cnt_ext[6:0];
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result.valid = ovalid_reg;
    assign result.data  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            total_reg  <= '0;
            headb_reg  <= '0;
            tail_reg   <= '0;
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            total_reg  <= total_next;
            headb_reg  <= headb_next;
            tail_reg   <= tail_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        fromhead_reg <= fromhead_next;
        b_reg        <= b_next;
        l_reg        <= l_next;
        t_reg        <= t_next;
        k_reg        <= k_next;
        shptr_reg    <= shptr_next;
        shcnt_reg    <= shcnt_next;
        shn_reg      <= shn_next;
        paddr_reg    <= paddr_next;
        wa_reg       <= wa_next;
        wd_reg       <= wd_next;
        wn_reg       <= wn_next;
        wi_reg       <= wi_next;
        st_reg       <= st_next;
        pos_reg      <= pos_next;
        rent_reg     <= rent_next;
        rsp_reg      <= rsp_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cnt_reg} <= MAXV)
        else $error("Region count exceeds the table size.");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg >= $past(cnt_reg))
        else $error("Region count decreased.");

    a_no_region_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && (rsp_reg.status == ST_OVERLAP || rsp_reg.status == ST_ZERO ||
         rsp_reg.status == ST_FULL || rsp_reg.status == ST_NOTFOUND))
        |-> (rsp_reg.position == 6'd0 && rsp_reg.found_length == 64'd0))
        else $error("Refused request reports a region.");
`endif
endmodule
